// ===== hdl/ts_packet_sync_tracker_assert.svh =====
// Assertion macros for the sync tracker checker file.
`ifndef TS_PACKET_SYNC_TRACKER_ASSERT_SVH
`define TS_PACKET_SYNC_TRACKER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TSPST_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sync tracker assertion failed");

// Next-cycle implication, checked outside reset.
`define TSPST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sync tracker assertion failed");

`endif

// ===== hdl/tspst_pkg.sv =====
// Shared constants, types and helper functions for the transport stream sync tracker.
`default_nettype none
package tspst_pkg;

	localparam int WinDepth = 613;
	localparam int FillW = $clog2(WinDepth + 1);

	localparam logic [7:0] SyncA = 8'h47;
	localparam logic [7:0] SyncB = 8'hB8;

	// Last byte index inside a packet for each length.
	localparam logic [7:0] ShortLast = 8'd187;
	localparam logic [7:0] LongLast = 8'd203;

	// Fixed window taps looked at while hunting.
	localparam int TapHead = 0;
	localparam int Tap188 = 188;
	localparam int Tap376 = 376;
	localparam int Tap564 = 564;
	localparam int Tap204 = 204;
	localparam int Tap408 = 408;
	localparam int Tap612 = WinDepth - 1;

	typedef enum logic {
		ST_HUNT,
		ST_LOCK
	} sync_state_t;

	typedef struct packed {
		logic [7:0] head;
		logic [7:0] t188;
		logic [7:0] t376;
		logic [7:0] t564;
		logic [7:0] t204;
		logic [7:0] t408;
		logic [7:0] t612;
	} taps_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       is_packet_byte;
		logic       packet_first;
		logic       packet_final;
		logic       long_packets;
		logic       lost_lock;
		logic       gained_lock;
	} result_t;

	function automatic logic is_sync(input logic [7:0] b);
		return (b == SyncA) || (b == SyncB);
	endfunction

endpackage
`default_nettype wire

// ===== hdl/tspst_cell.sv =====
// One byte cell of the lookahead chain; takes its neighbor's byte, or the input byte at the tail, on every shift.
`default_nettype none
module tspst_cell
	import tspst_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       shift_en,
	input  wire logic [7:0] d,
	output logic [7:0]      q
);

	logic [7:0] byte_q;

	always_ff @(posedge clk) begin
		if (shift_en) begin
			byte_q <= d;
		end
	end

	assign q = byte_q;

endmodule
`default_nettype wire

// ===== hdl/tspst_ctrl.sv =====
// Fill tracking, hunt/lock state machine and packet byte counter.
`default_nettype none
module tspst_ctrl
	import tspst_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  step,
	input  wire taps_t taps,
	output logic       res_valid,
	output result_t    res
);

	sync_state_t      state_q;
	sync_state_t      next_state;
	logic [FillW-1:0] fill_q;
	logic             ls_q;
	logic [7:0]       bip_q;

	logic       full;
	logic       lost;
	logic       still;
	logic       match_short;
	logic       match_long;
	logic       gain;
	logic       lock_now;
	logic       ls_n;
	logic [7:0] bip_b;
	logic [7:0] bip_c;
	logic [7:0] plen_last;
	logic       first;
	logic       final_b;
	logic [7:0] bip_n;

	assign full = (fill_q == FillW'(WinDepth));

	always_comb begin
		lost = (state_q == ST_LOCK) && (bip_q == 8'd0) && !is_sync(taps.head);
		still = (state_q == ST_LOCK) && !lost;
		match_short = (taps.head == SyncA) && (taps.t188 == SyncA) &&
			(taps.t376 == SyncA) && (taps.t564 == SyncA);
		match_long = is_sync(taps.head) && is_sync(taps.t204) &&
			is_sync(taps.t408) && is_sync(taps.t612);
		gain = !still && (match_short || match_long);
		lock_now = still || gain;
		if (gain) begin
			ls_n = !match_short;
		end else if (lost) begin
			ls_n = 1'b0;
		end else begin
			ls_n = ls_q;
		end
		bip_b = gain ? 8'd0 : bip_q;
		plen_last = ls_n ? LongLast : ShortLast;
		bip_c = (bip_b > plen_last) ? 8'd0 : bip_b;
		first = lock_now && (bip_c == 8'd0);
		final_b = lock_now && (bip_c == plen_last);
		if (lock_now) begin
			bip_n = final_b ? 8'd0 : bip_c + 8'd1;
		end else begin
			bip_n = bip_q;
		end
		case (lock_now)
			1'b1: next_state = ST_LOCK;
			default: next_state = ST_HUNT;
		endcase

		res_valid = full;
		res.out_byte = taps.head;
		res.is_packet_byte = lock_now;
		res.packet_first = first;
		res.packet_final = final_b;
		res.long_packets = lock_now && ls_n;
		res.lost_lock = lost;
		res.gained_lock = gain;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HUNT;
			fill_q <= '0;
			ls_q <= 1'b0;
			bip_q <= 8'd0;
		end else if (step) begin
			if (full) begin
				state_q <= next_state;
				ls_q <= ls_n;
				bip_q <= bip_n;
			end else begin
				fill_q <= fill_q + FillW'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ===== hdl/ts_packet_sync_tracker.sv =====
// Top level of the transport stream sync tracker: cell chain, control and output register.
//
//   Channel | Handshake            | Payload
//   --------+----------------------+------------------------------------------------
//   in      | in_valid / in_ready  | in_byte
//   out     | out_valid / out_ready| out_byte, is_packet_byte, packet_first,
//           |                      | packet_final, long_packets, lost_lock, gained_lock
//
// Every accepted item is decided in the cycle it is taken, so one item per cycle is
// sustained; the single output register sets this, and in_ready drops only while a
// result sits in it and out_ready is low.
// The first 613 items only fill the lookahead chain and produce no result.
// The chain has no reset and needs no clearing pass: the fill count keeps any byte that
// was never shifted in from reaching the decision.
// After reset in_ready is high, since the output register starts empty.
`default_nettype none
module ts_packet_sync_tracker
	import tspst_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] in_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_byte,
	output logic            is_packet_byte,
	output logic            packet_first,
	output logic            packet_final,
	output logic            long_packets,
	output logic            lost_lock,
	output logic            gained_lock
);

	logic       accept;
	logic [7:0] win [WinDepth];
	taps_t      taps;
	logic       res_valid;
	result_t    res;
	logic       out_valid_q;
	result_t    res_q;

	// A new item may enter whenever the output register is empty or being drained.
	assign in_ready = !out_valid_q || out_ready;
	assign accept = in_valid && in_ready;

	// The chain shifts toward the head on every accepted item; the new byte enters at
	// the tail, so the oldest byte always sits in cell zero once the chain is full.
	for (genvar i = 0; i < WinDepth; i++) begin : g_cell
		if (i == WinDepth - 1) begin : g_tail
			tspst_cell u_cell (
				.clk      (clk),
				.shift_en (accept),
				.d        (in_byte),
				.q        (win[i])
			);
		end else begin : g_body
			tspst_cell u_cell (
				.clk      (clk),
				.shift_en (accept),
				.d        (win[i+1]),
				.q        (win[i])
			);
		end
	end

	// Fixed taps used by the hunting search and the packet start check.
	always_comb begin
		taps.head = win[TapHead];
		taps.t188 = win[Tap188];
		taps.t376 = win[Tap376];
		taps.t564 = win[Tap564];
		taps.t204 = win[Tap204];
		taps.t408 = win[Tap408];
		taps.t612 = win[Tap612];
	end

	tspst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (accept),
		.taps      (taps),
		.res_valid (res_valid),
		.res       (res)
	);

	// Output register: loaded when an item with a result is taken, emptied when the
	// downstream side takes the result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && res_valid) begin
			res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte = res_q.out_byte;
	assign is_packet_byte = res_q.is_packet_byte;
	assign packet_first = res_q.packet_first;
	assign packet_final = res_q.packet_final;
	assign long_packets = res_q.long_packets;
	assign lost_lock = res_q.lost_lock;
	assign gained_lock = res_q.gained_lock;

endmodule
`default_nettype wire

// ===== hdl/tspst_checker.sv =====
// Port-level checker for the sync tracker and the bind that attaches it.
`default_nettype none
`include "ts_packet_sync_tracker_assert.svh"
module tspst_checker
	import tspst_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] out_byte,
	input wire logic       is_packet_byte,
	input wire logic       packet_first,
	input wire logic       packet_final,
	input wire logic       long_packets,
	input wire logic       lost_lock,
	input wire logic       gained_lock
);

	logic out_stall;
	logic framed;

	assign out_stall = out_valid && !out_ready;
	assign framed = packet_first || packet_final || long_packets || gained_lock;

	// A stalled result keeps its byte.
	`TSPST_ASSERT_NEXT(a_out_hold, clk, arst_n, out_stall, out_valid && $stable(out_byte))

	// With no result waiting, the block is always ready for an item.
	`TSPST_ASSERT_NOW(a_ready_when_empty, clk, arst_n, !out_valid, in_ready)

	// A dropped byte carries no packet framing and no acquisition.
	`TSPST_ASSERT_NOW(a_drop_clean, clk, arst_n, out_valid && !is_packet_byte, !framed)

	// Acquiring sync always starts a packet on that byte.
	`TSPST_ASSERT_NOW(a_gain_starts, clk, arst_n, out_valid && gained_lock,
		is_packet_byte && packet_first)

	// Losing sync without finding it again drops the byte.
	`TSPST_ASSERT_NOW(a_loss_drops, clk, arst_n, out_valid && lost_lock && !gained_lock,
		!is_packet_byte)

endmodule

bind ts_packet_sync_tracker tspst_checker u_checker (.*);
`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the transport stream sync tracker: stimulus, prediction, checking.
module tb;
	import tspst_pkg::*;

	// Kinds of stream segment that the random stimulus strings together.
	typedef enum int {
		SEG_NOISE,
		SEG_SHORT_RUN,
		SEG_LONG_RUN
	} segment_kind_t;

	// Bytes per packet for the two lengths the block knows.
	localparam int ShortLen = 188;
	localparam int LongLen = 204;

	// Number of stream bytes offered in total, directed opening included.
	localparam int RandomBytes = 1300;

	// Idling phases are switched on the number of items taken so far.
	localparam int PhaseOneEnd = 450;
	localparam int PhaseTwoEnd = 900;

	// The long receiver hold-off starts once this many results have come.
	localparam int HoldAfter = 350;
	localparam int HoldCycles = 300;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] in_byte = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] out_byte;
	logic       is_packet_byte;
	logic       packet_first;
	logic       packet_final;
	logic       long_packets;
	logic       lost_lock;
	logic       gained_lock;

	ts_packet_sync_tracker u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.in_byte        (in_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_byte       (out_byte),
		.is_packet_byte (is_packet_byte),
		.packet_first   (packet_first),
		.packet_final   (packet_final),
		.long_packets   (long_packets),
		.lost_lock      (lost_lock),
		.gained_lock    (gained_lock)
	);

	// A 4 unit clock period: two units high, two units low.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Stream bytes waiting to be offered, and the results that the predictor
	// says must still come out, oldest first.
	logic [7:0] pending_bytes [$];
	result_t    expected_bytes [$];

	// The taken and seen counters shared between processes are only ever updated with nonblocking
	// assignments, so a reader at the same edge always sees last cycle's value.
	int bytes_taken;
	int results_seen;
	int error_count = 0;

	// Receiver hold-off bookkeeping.
	int hold_left;
	bit hold_done;

	// Predictor state: our own copy of the lookahead window and the sync tracker.
	// Entries of the window are only read once the fill count says they were written.
	logic [7:0] sync_window [0:WinDepth-1];
	int         window_fill = 0;
	bit         track_locked = 1'b0;
	bit         track_long = 1'b0;
	int         track_pos = 0;

	result_t exp_item;
	result_t pred_item;

	// A byte that may start a packet while locked, or mark a 204-byte packet.
	function automatic bit sync_mark(input logic [7:0] b);
		return (b == SyncA) || (b == SyncB);
	endfunction

	// Feeds one byte into the predicted tracker. Returns 1 and fills res when
	// the byte pushes the head of the window out, which happens only once the
	// window is full.
	function automatic bit track_byte(input logic [7:0] nb, output result_t res);
		logic [7:0] head;
		bit         lost;
		bit         gained;
		bit         first;
		bit         last_byte;
		int         plen;

		res = '0;
		if (window_fill < WinDepth) begin
			sync_window[window_fill] = nb;
			window_fill++;
			return 1'b0;
		end

		head = sync_window[0];
		lost = 1'b0;
		gained = 1'b0;
		first = 1'b0;
		last_byte = 1'b0;

		// A packet start that carries no sync byte drops the lock; hunting then
		// runs on the very same head byte below.
		if (track_locked && track_pos == 0 && !sync_mark(head)) begin
			track_locked = 1'b0;
			track_long = 1'b0;
			lost = 1'b1;
		end

		if (!track_locked) begin
			if (sync_window[0] == SyncA && sync_window[188] == SyncA &&
					sync_window[376] == SyncA && sync_window[564] == SyncA) begin
				track_locked = 1'b1;
				track_long = 1'b0;
				track_pos = 0;
				gained = 1'b1;
			end else if (sync_mark(sync_window[0]) && sync_mark(sync_window[204]) &&
					sync_mark(sync_window[408]) && sync_mark(sync_window[612])) begin
				track_locked = 1'b1;
				track_long = 1'b1;
				track_pos = 0;
				gained = 1'b1;
			end
		end

		if (track_locked) begin
			plen = track_long ? LongLen : ShortLen;
			if (track_pos >= plen)
				track_pos = 0;
			first = (track_pos == 0);
			last_byte = (track_pos == plen - 1);
			track_pos = last_byte ? 0 : track_pos + 1;
		end

		res.out_byte = head;
		res.is_packet_byte = track_locked;
		res.packet_first = first;
		res.packet_final = last_byte;
		res.long_packets = track_locked && track_long;
		res.lost_lock = lost;
		res.gained_lock = gained;

		for (int i = 0; i < WinDepth - 1; i++)
			sync_window[i] = sync_window[i + 1];
		sync_window[WinDepth - 1] = nb;
		return 1'b1;
	endfunction

	// Idle percentage for one side in the current phase: first the sender idles
	// lightly and the receiver heavily, then the other way round, then neither.
	function automatic int idle_pct(input bit sender);
		if (bytes_taken < PhaseOneEnd)
			return sender ? 18 : 73;
		else if (bytes_taken < PhaseTwoEnd)
			return sender ? 73 : 18;
		return 0;
	endfunction

	// Reports one field of a result that differs from the prediction.
	task automatic check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			error_count++;
		end
	endtask

	// Appends a random byte; now and then a sync value so that stray marks
	// show up inside noise and packet bodies.
	task automatic push_random_byte(input int sync_odds);
		int pick;
		pick = $urandom_range(99);
		if (pick < sync_odds)
			pending_bytes.push_back(pick[0] ? SyncA : SyncB);
		else
			pending_bytes.push_back(8'($urandom));
	endtask

	// Builds the random part of the stream. Most of it is well-formed packet
	// runs, long enough that the hunter sees four aligned sync bytes, with an
	// occasional broken sync byte to knock the tracker out of lock. Short bursts
	// of noise between runs make it drop bytes and hunt again.
	task automatic build_stream();
		segment_kind_t kind;
		int            added;
		int            pick;
		int            packets;
		int            plen;
		logic [7:0]    mark;

		added = 0;
		while (added < RandomBytes) begin
			pick = $urandom_range(99);
			kind = (pick < 20) ? SEG_NOISE : (pick < 65) ? SEG_SHORT_RUN : SEG_LONG_RUN;
			if (kind == SEG_NOISE) begin
				packets = $urandom_range(120, 1);
				for (int i = 0; i < packets; i++)
					push_random_byte(12);
				added += packets;
			end else begin
				packets = $urandom_range(6, 4);
				plen = (kind == SEG_LONG_RUN) ? LongLen : ShortLen;
				for (int p = 0; p < packets; p++) begin
					pick = $urandom_range(99);
					if (kind == SEG_LONG_RUN)
						mark = pick[0] ? SyncA : SyncB;
					else
						mark = SyncA;
					// A 188-byte stream that is already locked also accepts the
					// other sync value at a packet start.
					if (kind == SEG_SHORT_RUN && pick >= 88)
						mark = SyncB;
					// A corrupted sync byte is the way the lock gets lost.
					if (pick < 8) begin
						mark = 8'($urandom);
						if (sync_mark(mark))
							mark = ~mark ^ 8'h01;
					end
					pending_bytes.push_back(mark);
					for (int i = 1; i < plen; i++)
						push_random_byte(2);
				end
				added += packets * plen;
			end
		end
		// The last segment may run past the target; cut the stream back to it.
		if (pending_bytes.size() > RandomBytes)
			pending_bytes = pending_bytes[0:RandomBytes-1];
	endtask

	// Driver: presents the next queued byte whenever the previous one has been
	// taken or nothing is being offered. Valid is held with the byte unchanged
	// until the block accepts it.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_byte <= 8'h00;
		end else if (!in_valid || in_ready) begin
			if (pending_bytes.size() != 0 && $urandom_range(99) >= idle_pct(1'b1)) begin
				in_valid <= 1'b1;
				in_byte <= pending_bytes.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: random ready, plus one long hold-off in the phase without idling
	// so the output register fills and the block has to refuse input.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!hold_done && results_seen >= HoldAfter) begin
			out_ready <= 1'b0;
			hold_left <= HoldCycles;
			hold_done <= 1'b1;
		end else begin
			out_ready <= ($urandom_range(99) >= idle_pct(1'b0));
		end
	end

	// Monitor: checks each result against the oldest prediction, then runs the
	// predictor on an item taken at this edge. A result can never belong to an
	// item taken at the same edge, since the block registers its output.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_taken <= 0;
			results_seen <= 0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen <= results_seen + 1;
				if (expected_bytes.size() == 0) begin
					$display("%0t: result with none expected, actual byte %0h",
						$time, out_byte);
					error_count++;
				end else begin
					exp_item = expected_bytes.pop_front();
					check_field("out_byte", exp_item.out_byte, out_byte);
					check_field("is_packet_byte", 8'(exp_item.is_packet_byte),
						8'(is_packet_byte));
					check_field("packet_first", 8'(exp_item.packet_first), 8'(packet_first));
					check_field("packet_final", 8'(exp_item.packet_final), 8'(packet_final));
					check_field("long_packets", 8'(exp_item.long_packets), 8'(long_packets));
					check_field("lost_lock", 8'(exp_item.lost_lock), 8'(lost_lock));
					check_field("gained_lock", 8'(exp_item.gained_lock), 8'(gained_lock));
				end
			end
			if (in_valid && in_ready) begin
				bytes_taken <= bytes_taken + 1;
				if (track_byte(in_byte, pred_item))
					expected_bytes.push_back(pred_item);
			end
		end
	end

	// Main sequence: build the stream, release reset, then wait for the block
	// to drain. The last 613 bytes stay in the window and never come out.
	initial begin
		// Directed opening: field extremes, both sync values and their
		// neighbors, and alternating and single-bit patterns.
		pending_bytes.push_back(8'h00);
		pending_bytes.push_back(8'hFF);
		pending_bytes.push_back(SyncA);
		pending_bytes.push_back(SyncB);
		pending_bytes.push_back(8'h46);
		pending_bytes.push_back(8'h48);
		pending_bytes.push_back(8'hB7);
		pending_bytes.push_back(8'hB9);
		pending_bytes.push_back(8'h55);
		pending_bytes.push_back(8'hAA);
		pending_bytes.push_back(8'h01);
		pending_bytes.push_back(8'h80);
		pending_bytes.push_back(8'h7F);
		pending_bytes.push_back(8'hFE);
		build_stream();

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_bytes.size() != 0 || in_valid)
			@(posedge clk);
		while (expected_bytes.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);

		if (error_count == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

	// Watchdog, far beyond the slowest correct run.
	initial begin
		#1000000;
		$display("tb: errors");
		$finish;
	end

endmodule
